FILE: design/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// Used by the front end, the job queue, the pixel emitter and the top level.
package mcr_pkg;

	localparam int RADIUS_BITS = 9;
	localparam int COLOR_BITS  = 4;
	localparam int CENTER_BITS = 10;
	localparam int COORD_BITS  = 12;

	// Offsets run down to -1 on the final iteration, so one extra bit for the sign.
	localparam int OFF_BITS = RADIUS_BITS + 1;
	// The decision term and its deltas stay within about four times the radius.
	localparam int DEC_BITS = RADIUS_BITS + 4;
	localparam int EXT_BITS = (OFF_BITS > COORD_BITS) ? OFF_BITS : COORD_BITS;

	localparam int FIFO_DEPTH    = 2;
	localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam int PIX_PER_STEP = 8;
	localparam int PIX_IDX_BITS = $clog2(PIX_PER_STEP);

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_type_t;

	// One iteration's worth of work for the emitter.
	typedef struct packed {
		logic [CENTER_BITS-1:0]     cx;
		logic [CENTER_BITS-1:0]     cy;
		logic signed [OFF_BITS-1:0] x;
		logic signed [OFF_BITS-1:0] y;
		logic [COLOR_BITS-1:0]      color;
		logic                       done;
	} job_t;

endpackage

FILE: design/mcr_front.sv
// Front end: accepts start and step items, runs the midpoint decision update
// and pushes one job per active step. Depends on mcr_pkg.
module mcr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [mcr_pkg::CENTER_BITS-1:0] center_x,
	input  logic [mcr_pkg::CENTER_BITS-1:0] center_y,
	input  logic [mcr_pkg::RADIUS_BITS-1:0] radius,
	input  logic [mcr_pkg::COLOR_BITS-1:0]  pen_color,
	input  logic                          q_full,
	output logic                          push,
	output mcr_pkg::job_t                 push_job
);
	import mcr_pkg::*;

	logic                       busy_q;
	logic signed [OFF_BITS-1:0] off_x_q, off_y_q;
	logic signed [DEC_BITS-1:0] dec_q, de_q, dne_q;
	logic [CENTER_BITS-1:0]     cx_q, cy_q;
	logic [COLOR_BITS-1:0]      color_q;

	logic                       acc, is_start, is_step;
	logic signed [OFF_BITS-1:0] x_n, y_n;
	logic signed [DEC_BITS-1:0] dec_n, de_n, dne_n, r_dec;
	logic                       done_n;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign is_start = acc && (req_type_t'(req_type) == REQ_START);
	assign is_step  = acc && (req_type_t'(req_type) == REQ_STEP);
	assign push     = is_step && busy_q;
	assign r_dec    = DEC_BITS'(radius);

	always_comb begin
		x_n  = off_x_q + OFF_BITS'(1);
		de_n = de_q + DEC_BITS'(2);
		if (dec_q < 0) begin
			dec_n = dec_q + de_q;
			dne_n = dne_q + DEC_BITS'(2);
			y_n   = off_y_q;
		end else begin
			dec_n = dec_q + dne_q;
			dne_n = dne_q + DEC_BITS'(4);
			y_n   = off_y_q - OFF_BITS'(1);
		end
		done_n = y_n < x_n;
	end

	always_comb begin
		push_job.cx    = cx_q;
		push_job.cy    = cy_q;
		push_job.x     = off_x_q;
		push_job.y     = off_y_q;
		push_job.color = color_q;
		push_job.done  = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (is_start) begin
			busy_q <= 1'b1;
		end else if (push && done_n) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_start) begin
			off_x_q <= '0;
			off_y_q <= OFF_BITS'(radius);
			dec_q   <= DEC_BITS'(1) - r_dec;
			de_q    <= DEC_BITS'(3);
			dne_q   <= DEC_BITS'(5) - (r_dec <<< 1);
			cx_q    <= center_x;
			cy_q    <= center_y;
			color_q <= pen_color;
		end else if (push) begin
			off_x_q <= x_n;
			off_y_q <= y_n;
			dec_q   <= dec_n;
			de_q    <= de_n;
			dne_q   <= dne_n;
		end
	end

	a_push_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> busy_q && in_valid && !q_full)
		else $error("job pushed while idle or stalled");
	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		is_start |=> busy_q)
		else $error("start did not set busy");
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(push && done_n))
		else $error("busy cleared without a final iteration");

endmodule

FILE: design/mcr_fifo.sv
// Short job queue between the front end and the pixel emitter.
// Depends on mcr_pkg for the job type and depth.
module mcr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mcr_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output mcr_pkg::job_t head_job
);
	import mcr_pkg::*;

	job_t                     mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;

	assign full       = count_q == FIFO_CNT_BITS'(FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("queue count beyond depth");

endmodule

FILE: design/mcr_emit.sv
// Pixel emitter: expands one job into the eight symmetric writes, one per beat,
// through a registered output stage. Depends on mcr_pkg.
module mcr_emit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  mcr_pkg::job_t                       head_job,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [mcr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [mcr_pkg::COORD_BITS-1:0] pixel_y,
	output logic [mcr_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                                last_pixel
);
	import mcr_pkg::*;

	job_t                       job_q;
	logic                       active_q;
	logic [PIX_IDX_BITS-1:0]    idx_q;
	logic                       out_valid_q, last_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [COLOR_BITS-1:0]      color_q;

	logic                       adv, end_job;
	logic signed [EXT_BITS-1:0]   x_ext, y_ext;
	logic signed [COORD_BITS-1:0] xo, yo, dx, dy, px_n, py_n;

	assign adv     = active_q && (!out_valid_q || out_ready);
	assign end_job = adv && (idx_q == PIX_IDX_BITS'(PIX_PER_STEP - 1));
	assign pop     = head_valid && (!active_q || end_job);

	assign x_ext = EXT_BITS'(job_q.x);
	assign y_ext = EXT_BITS'(job_q.y);
	assign xo    = COORD_BITS'(x_ext);
	assign yo    = COORD_BITS'(y_ext);

	// Octant order: (x,y) (y,x) (y,-x) (x,-y) (-x,-y) (-y,-x) (-y,x) (-x,y).
	always_comb begin
		case (idx_q)
			3'd0: begin dx = xo;  dy = yo;  end
			3'd1: begin dx = yo;  dy = xo;  end
			3'd2: begin dx = yo;  dy = -xo; end
			3'd3: begin dx = xo;  dy = -yo; end
			3'd4: begin dx = -xo; dy = -yo; end
			3'd5: begin dx = -yo; dy = -xo; end
			3'd6: begin dx = -yo; dy = xo;  end
			3'd7: begin dx = -xo; dy = yo;  end
			default: begin dx = xo; dy = yo; end
		endcase
		px_n = COORD_BITS'(job_q.cx) + dx;
		py_n = COORD_BITS'(job_q.cy) + dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (end_job) begin
				active_q <= 1'b0;
				idx_q    <= '0;
			end else if (adv) begin
				idx_q <= idx_q + PIX_IDX_BITS'(1);
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (adv) begin
			px_q    <= px_n;
			py_q    <= py_n;
			color_q <= job_q.color;
			last_q  <= end_job && job_q.done;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = color_q;
	assign last_pixel  = last_q;

	a_idx_active: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> active_q)
		else $error("pixel index moved without a job");
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv && idx_q != PIX_IDX_BITS'(PIX_PER_STEP - 1) |=> !last_q)
		else $error("last flag set before the eighth write");

endmodule

FILE: design/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer, top level. A step item goes through the job queue,
// the emitter's job register and its output register; a start item gives no output.
// Each active step gives eight writes on the single output port; the two-entry
// job queue lets up to two further steps be taken while one emits.
// Reset (arst_n low) drops any circle in progress and empties the queue.
module midpoint_circle_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [mcr_pkg::CENTER_BITS-1:0]     center_x,
	input  logic [mcr_pkg::CENTER_BITS-1:0]     center_y,
	input  logic [mcr_pkg::RADIUS_BITS-1:0]     radius,
	input  logic [mcr_pkg::COLOR_BITS-1:0]      pen_color,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [mcr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [mcr_pkg::COORD_BITS-1:0] pixel_y,
	output logic [mcr_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                                last_pixel
);
	import mcr_pkg::*;

	logic q_full, push, pop, head_valid;
	job_t push_job, head_job;

	mcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.pen_color(pen_color),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	mcr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	mcr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last_pixel (last_pixel)
	);

endmodule

FILE: bench/circle_pixel_checker.sv
// Checker for the midpoint circle rasterizer: predicts the pixel writes of every
// accepted request beat and compares each accepted output beat with them.
// Depends on mcr_pkg for the field widths and the request encoding.
module circle_pixel_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic                                  req_type,
	input  logic [mcr_pkg::CENTER_BITS-1:0]       center_x,
	input  logic [mcr_pkg::CENTER_BITS-1:0]       center_y,
	input  logic [mcr_pkg::RADIUS_BITS-1:0]       radius,
	input  logic [mcr_pkg::COLOR_BITS-1:0]        pen_color,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [mcr_pkg::COORD_BITS-1:0] pixel_x,
	input  logic signed [mcr_pkg::COORD_BITS-1:0] pixel_y,
	input  logic [mcr_pkg::COLOR_BITS-1:0]        pixel_color,
	input  logic                                  last_pixel,
	output int                                    mismatches,
	output int                                    writes_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mcr_pkg::*;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0]        color;
		logic                         last;
	} pixel_write_t;

	logic                        circle_live;
	logic signed [OFF_BITS-1:0]  arc_x;
	logic signed [OFF_BITS-1:0]  arc_y;
	logic signed [DEC_BITS-1:0]  decision;
	logic signed [DEC_BITS-1:0]  east_delta;
	logic signed [DEC_BITS-1:0]  northeast_delta;
	logic [CENTER_BITS-1:0]      origin_x;
	logic [CENTER_BITS-1:0]      origin_y;
	logic [COLOR_BITS-1:0]       ink;
	pixel_write_t                expected_writes[$];

	task automatic report_mismatch(input string msg);
		$display("%0t: pixel mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Coordinates wrap to the output width, as the block does not clip.
	function automatic logic signed [COORD_BITS-1:0] place(input logic [CENTER_BITS-1:0] base,
			input int off);
		int sum;
		sum = int'(base) + off;
		return sum[COORD_BITS-1:0];
	endfunction

	task automatic queue_write(input int dx, input int dy, input logic last);
		expected_writes.push_back(pixel_write_t'{place(origin_x, dx), place(origin_y, dy),
			ink, last});
	endtask

	task automatic rasterize_request(input logic req, input logic [CENTER_BITS-1:0] cx,
			input logic [CENTER_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] r,
			input logic [COLOR_BITS-1:0] color);
		int   x;
		int   y;
		logic finished;
		if (req == REQ_START) begin
			origin_x        = cx;
			origin_y        = cy;
			ink             = color;
			arc_x           = '0;
			arc_y           = OFF_BITS'(r);
			decision        = DEC_BITS'(1 - int'(r));
			east_delta      = DEC_BITS'(3);
			northeast_delta = DEC_BITS'(5 - 2 * int'(r));
			circle_live     = 1'b1;
		end else if (circle_live) begin
			x = int'(arc_x);
			y = int'(arc_y);
			if (decision < 0) begin
				decision        += east_delta;
				east_delta      += DEC_BITS'(2);
				northeast_delta += DEC_BITS'(2);
			end else begin
				decision        += northeast_delta;
				east_delta      += DEC_BITS'(2);
				northeast_delta += DEC_BITS'(4);
				arc_y           -= OFF_BITS'(1);
			end
			arc_x += OFF_BITS'(1);
			finished = (arc_y < arc_x);
			if (finished)
				circle_live = 1'b0;
			queue_write(x, y, 1'b0);
			queue_write(y, x, 1'b0);
			queue_write(y, -x, 1'b0);
			queue_write(x, -y, 1'b0);
			queue_write(-x, -y, 1'b0);
			queue_write(-y, -x, 1'b0);
			queue_write(-y, x, 1'b0);
			queue_write(-x, y, finished);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_write_t want;
		if (!arst_n) begin
			circle_live     = 1'b0;
			arc_x           = '0;
			arc_y           = '0;
			decision        = '0;
			east_delta      = '0;
			northeast_delta = '0;
			origin_x        = '0;
			origin_y        = '0;
			ink             = '0;
			expected_writes.delete();
			writes_pending <= 0;
		end else begin
			// Output first, so that a beat cannot match writes queued at the same edge.
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected write (%0d,%0d) color %0d last %0b",
						pixel_x, pixel_y, pixel_color, last_pixel));
				end else begin
					want = expected_writes.pop_front();
					if (pixel_x !== want.x || pixel_y !== want.y ||
							pixel_color !== want.color || last_pixel !== want.last)
						report_mismatch($sformatf(
							"got (%0d,%0d) color %0d last %0b, want (%0d,%0d) color %0d last %0b",
							pixel_x, pixel_y, pixel_color, last_pixel,
							want.x, want.y, want.color, want.last));
				end
			end
			if (in_valid && in_ready)
				rasterize_request(req_type, center_x, center_y, radius, pen_color);
			writes_pending <= expected_writes.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// Top of the midpoint circle rasterizer bench: clock, reset, request stimulus,
// output stalls, watchdog and verdict. Depends on mcr_pkg, the rasterizer and
// circle_pixel_checker, which does all prediction and comparison.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mcr_pkg::*;

	localparam int QUIET_LIMIT     = 2000;
	localparam int TAIL_CYCLES     = 16;
	localparam int RANDOM_REQUESTS = 200;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          req_type;
	logic [CENTER_BITS-1:0]        center_x;
	logic [CENTER_BITS-1:0]        center_y;
	logic [RADIUS_BITS-1:0]        radius;
	logic [COLOR_BITS-1:0]         pen_color;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [COORD_BITS-1:0]  pixel_x;
	logic signed [COORD_BITS-1:0]  pixel_y;
	logic [COLOR_BITS-1:0]         pixel_color;
	logic                          last_pixel;

	int mismatches;
	int writes_pending;
	int send_idle_pct;
	int recv_stall_pct;

	midpoint_circle_rasterizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.pen_color   (pen_color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	circle_pixel_checker pixel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.center_x       (center_x),
		.center_y       (center_y),
		.radius         (radius),
		.pen_color      (pen_color),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_color    (pixel_color),
		.last_pixel     (last_pixel),
		.mismatches     (mismatches),
		.writes_pending (writes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Ends the run when neither channel has moved a beat for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no beat for %0d cycles, %0d writes outstanding",
			QUIET_LIMIT, writes_pending);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Iterations a circle of radius r needs, rounded so that it is never short.
	function automatic int octant_steps(input int r);
		return (r * 181) / 256 + 1;
	endfunction

	task automatic send_request(input logic req, input logic [CENTER_BITS-1:0] cx,
			input logic [CENTER_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] r,
			input logic [COLOR_BITS-1:0] color);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		req_type  <= req;
		center_x  <= cx;
		center_y  <= cy;
		radius    <= r;
		pen_color <= color;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Step beats carry random fields, which the block must ignore.
	task automatic trace_circle(input int cx, input int cy, input int r, input int color,
			input int steps);
		send_request(REQ_START, CENTER_BITS'(cx), CENTER_BITS'(cy), RADIUS_BITS'(r),
			COLOR_BITS'(color));
		repeat (steps)
			send_request(REQ_STEP, CENTER_BITS'($urandom_range(0, 1023)),
				CENTER_BITS'($urandom_range(0, 1023)), RADIUS_BITS'($urandom_range(0, 511)),
				COLOR_BITS'($urandom_range(0, 15)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (writes_pending != 0);
	endtask

	initial begin
		int r;
		int full;
		int steps;
		int extra;
		int pick;
		int phase;
		int cur_phase;
		int counted;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = REQ_START;
		center_x       = '0;
		center_y       = '0;
		radius         = '0;
		pen_color      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: step while idle, zero radius, the largest radius abandoned by a
		// new start, field extremes and both decision cases.
		send_request(REQ_STEP, 10'h3FF, 10'h3FF, 9'h1FF, 4'hF);
		trace_circle(0, 0, 0, 15, 2);
		trace_circle(1023, 1023, 511, 0, 3);
		trace_circle(0, 1023, 1, 5, 2);
		trace_circle(1023, 0, 5, 10, 5);
		trace_circle(512, 341, 3, 6, octant_steps(3) + 1);
		wait_drained();

		cur_phase = 0;
		counted   = 0;
		while (counted < RANDOM_REQUESTS) begin
			phase = counted * 4 / RANDOM_REQUESTS;
			if (phase != cur_phase) begin
				wait_drained();
				cur_phase = phase;
				case (phase)
					1: begin
						send_idle_pct   = 79;
						recv_stall_pct <= 0;
					end
					2: begin
						send_idle_pct   = 0;
						recv_stall_pct <= 79;
					end
					default: begin
						send_idle_pct   = 15;
						recv_stall_pct <= 15;
					end
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_request(1'($urandom_range(0, 1)), CENTER_BITS'($urandom_range(0, 1023)),
					CENTER_BITS'($urandom_range(0, 1023)), RADIUS_BITS'($urandom_range(0, 511)),
					COLOR_BITS'($urandom_range(0, 15)));
				counted += 1;
			end else if (pick < 25) begin
				// Abandoned circle: any radius, cut short by the next start.
				r     = $urandom_range(0, 511);
				full  = octant_steps(r);
				steps = $urandom_range(0, (full - 1 < 12) ? full - 1 : 12);
				trace_circle($urandom_range(0, 1023), $urandom_range(0, 1023), r,
					$urandom_range(0, 15), steps);
				counted += 1 + steps;
			end else begin
				if ($urandom_range(0, 24) == 0)
					r = $urandom_range(40, 120);
				else if ($urandom_range(0, 7) == 0)
					r = $urandom_range(13, 40);
				else
					r = $urandom_range(0, 12);
				full  = octant_steps(r);
				extra = $urandom_range(0, 2);
				// A few extra steps land on an idle block after the last write.
				trace_circle($urandom_range(0, 1023), $urandom_range(0, 1023), r,
					$urandom_range(0, 15), full + extra);
				counted += 1 + full + extra;
				if ($urandom_range(0, 9) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && writes_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: midpoint_circle_rasterizer.f
design/mcr_pkg.sv
design/mcr_front.sv
design/mcr_fifo.sv
design/mcr_emit.sv
design/midpoint_circle_rasterizer.sv
bench/circle_pixel_checker.sv
bench/testbench.sv
